// File: sv/gab_pkg.sv
// ----------------------------------------------------------------------------
// gab_pkg: shared types and constants of the scaled matrix multiply engine.
// Holds request codes, register indexes, datapath widths and control codes.
// ----------------------------------------------------------------------------
`default_nettype none

package gab_pkg;

  localparam int ELEM_W     = 16;
  localparam int IDX_W      = 3;
  localparam int DIM_W      = 4;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int OPA_W  = ELEM_W + 1;
  localparam int OPB_W  = ELEM_W + 2;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = 35;
  localparam int LO_W   = 17;
  localparam int TOT_W  = 50;
  localparam int Q_W    = TOT_W - 16;

  localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_C  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_N     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_M    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_K     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_GAIN  = 3'd4;

  localparam logic [DIM_W-1:0]  DIM_RESET   = 4'd8;
  localparam logic [ELEM_W-1:0] ALPHA_RESET = 16'd256;
  localparam logic [ELEM_W-1:0] BETA_RESET  = 16'd0;

  localparam logic [1:0] OP_MAC      = 2'd0;
  localparam logic [1:0] OP_ALPHA_HI = 2'd1;
  localparam logic [1:0] OP_ALPHA_LO = 2'd2;
  localparam logic [1:0] OP_BETA_C   = 2'd3;

  localparam logic [1:0] TOT_HOLD    = 2'd0;
  localparam logic [1:0] TOT_LOAD_HI = 2'd1;
  localparam logic [1:0] TOT_ADD     = 2'd2;
  localparam logic [1:0] TOT_ADD8    = 2'd3;

  typedef struct packed {
    logic [1:0] op_sel;
    logic       acc_clr;
    logic       acc_en;
    logic [1:0] tot_sel;
  } gab_ctl_t;

endpackage

`default_nettype wire

// File: sv/gab_ram.sv
// ----------------------------------------------------------------------------
// gab_ram: generic single-write, single-read memory.
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gab_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: sv/gab_datapath.sv
// ----------------------------------------------------------------------------
// gab_datapath: shared multiplier with accumulator and scaling total.
// One signed multiplier serves the dot product, the alpha scaling in two
// halves and the beta scaling; the total is rounded toward zero and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module gab_datapath (
  input  wire logic                         clk,
  input  wire gab_pkg::gab_ctl_t            ctl,
  input  wire logic [gab_pkg::ELEM_W-1:0]   a_data,
  input  wire logic [gab_pkg::ELEM_W-1:0]   b_data,
  input  wire logic [gab_pkg::ELEM_W-1:0]   c_data,
  input  wire logic [gab_pkg::ELEM_W-1:0]   alpha,
  input  wire logic [gab_pkg::ELEM_W-1:0]   beta,
  output logic      [gab_pkg::ELEM_W-1:0]   res_value,
  output logic                              res_sat
);

  import gab_pkg::*;

  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
  localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(32768);

  logic signed [OPA_W-1:0]  op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic signed [PROD_W-1:0] product;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [TOT_W-1:0]  tot_r, tot_nxt;
  logic signed [TOT_W-1:0]  prod_ext;
  logic signed [Q_W-1:0]    q;
  logic                     round_up;

  always_comb begin
    case (ctl.op_sel)
      OP_MAC: begin
        op_a = OPA_W'(signed'(a_data));
        op_b = OPB_W'(signed'(b_data));
      end
      OP_ALPHA_HI: begin
        op_a = OPA_W'(signed'(alpha));
        op_b = OPB_W'(signed'(acc_r[ACC_W-1:LO_W]));
      end
      OP_ALPHA_LO: begin
        op_a = OPA_W'(signed'(alpha));
        op_b = signed'({1'b0, acc_r[LO_W-1:0]});
      end
      OP_BETA_C: begin
        op_a = OPA_W'(signed'(beta));
        op_b = OPB_W'(signed'(c_data));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign product  = op_a * op_b;
  assign prod_ext = TOT_W'(prod_r);

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.acc_clr) begin
      acc_nxt = '0;
    end else if (ctl.acc_en) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  always_comb begin
    case (ctl.tot_sel)
      TOT_HOLD:    tot_nxt = tot_r;
      TOT_LOAD_HI: tot_nxt = prod_ext <<< LO_W;
      TOT_ADD:     tot_nxt = tot_r + prod_ext;
      TOT_ADD8:    tot_nxt = tot_r + (prod_ext <<< 8);
      default:     tot_nxt = tot_r;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= product;
    acc_r  <= acc_nxt;
    tot_r  <= tot_nxt;
  end

  assign round_up = tot_r[TOT_W-1] && (tot_r[15:0] != 16'd0);
  assign q = signed'(tot_r[TOT_W-1:16]) + Q_W'(round_up);

  always_comb begin
    if (q > Q_MAX) begin
      res_value = 16'h7fff;
      res_sat   = 1'b1;
    end else if (q < Q_MIN) begin
      res_value = 16'h8000;
      res_sat   = 1'b1;
    end else begin
      res_value = q[ELEM_W-1:0];
      res_sat   = 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: sv/gemm_alpha_beta_engine.sv
// ----------------------------------------------------------------------------
// gemm_alpha_beta_engine: scaled matrix multiply, C = alpha*A*B + beta*C.
// Usage: a request is taken at a clock edge with start high and busy low.
// Load requests (A, B or C) write one Q8.8 element at row and column at
// the accepting edge and leave busy low, so loads can follow every cycle. A
// compute request raises busy and walks C in row-major order. Each element
// runs the inner dimension m through one shared multiplier (one product per
// cycle, through the memory read and product registers), then states P0 to
// P3 do the alpha and beta scaling on the same multiplier and state OUT emits
// the result. Each result is shown for one cycle with out_valid, the cycle
// after it is formed; the last one carries out_last. Results are written
// back into C. The receiver cannot stall. Configuration writes through
// cfg_we take effect at once and belong in idle time. Reset returns the
// registers to their defaults and the sequencer to idle; the element
// memories keep their contents and must be loaded before use.
// ----------------------------------------------------------------------------
`default_nettype none

module gemm_alpha_beta_engine #(
  parameter int MAX_DIM = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [gab_pkg::CMD_W-1:0]        in_command,
  input  wire logic [gab_pkg::IDX_W-1:0]        in_row_index,
  input  wire logic [gab_pkg::IDX_W-1:0]        in_col_index,
  input  wire logic [gab_pkg::ELEM_W-1:0]       in_element_value,
  output logic                                  out_valid,
  output logic      [gab_pkg::IDX_W-1:0]        out_row,
  output logic      [gab_pkg::IDX_W-1:0]        out_col,
  output logic      [gab_pkg::ELEM_W-1:0]       out_value,
  output logic                                  out_saturated,
  output logic                                  out_last,
  input  wire logic                             cfg_we,
  input  wire logic [gab_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gab_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import gab_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_P0   = 3'd2;
  localparam logic [2:0] S_P1   = 3'd3;
  localparam logic [2:0] S_P2   = 3'd4;
  localparam logic [2:0] S_P3   = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  function automatic logic [AW-1:0] addr_of(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    addr_of = AW'((32'(r) * MAX_DIM) + 32'(c));
  endfunction

  function automatic logic [DIM_W-1:0] dim_of(logic [DIM_W-1:0] v);
    if (v == '0) begin
      dim_of = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      dim_of = DIM_W'(MAX_DIM);
    end else begin
      dim_of = v;
    end
  endfunction

  logic [DIM_W-1:0]  rows_n_r, inner_m_r, cols_k_r;
  logic [ELEM_W-1:0] alpha_r, beta_r;

  logic [2:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt, j_r, j_nxt;
  logic [DIM_W-1:0]  cnt_r, cnt_nxt;
  logic              rdv_r, rdv_nxt, pv_r, pv_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_row_r, out_col_r;
  logic [ELEM_W-1:0] out_value_r;
  logic              out_sat_r, out_last_r;

  logic [DIM_W-1:0]  dim_n, dim_m, dim_k;
  logic              accept, load_ok, is_last;
  gab_ctl_t          ctl;

  logic [AW-1:0]     load_addr, a_raddr, b_raddr, c_addr, c_waddr;
  logic              a_we, b_we, c_we;
  logic [ELEM_W-1:0] c_wdata;
  logic [ELEM_W-1:0] a_rdata, b_rdata, c_rdata;
  logic [ELEM_W-1:0] res_value;
  logic              res_sat;

  assign dim_n  = dim_of(rows_n_r);
  assign dim_m  = dim_of(inner_m_r);
  assign dim_k  = dim_of(cols_k_r);
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign load_ok   = accept && (in_command != CMD_COMPUTE) &&
                     (32'(in_row_index) < MAX_DIM) && (32'(in_col_index) < MAX_DIM);
  assign load_addr = addr_of(in_row_index, in_col_index);
  assign a_we      = load_ok && (in_command == CMD_LOAD_A);
  assign b_we      = load_ok && (in_command == CMD_LOAD_B);

  assign a_raddr = addr_of(i_r, cnt_r[IDX_W-1:0]);
  assign b_raddr = addr_of(cnt_r[IDX_W-1:0], j_r);
  assign c_addr  = addr_of(i_r, j_r);

  assign is_last = ({1'b0, i_r} == dim_n - DIM_W'(1)) &&
                   ({1'b0, j_r} == dim_k - DIM_W'(1));

  always_comb begin
    if (state_r == S_OUT) begin
      c_we    = 1'b1;
      c_waddr = c_addr;
      c_wdata = res_value;
    end else begin
      c_we    = load_ok && (in_command == CMD_LOAD_C);
      c_waddr = load_addr;
      c_wdata = in_element_value;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    cnt_nxt       = cnt_r;
    rdv_nxt       = 1'b0;
    pv_nxt        = 1'b0;
    out_valid_nxt = 1'b0;
    ctl           = '{op_sel: OP_MAC, acc_clr: 1'b0, acc_en: 1'b0, tot_sel: TOT_HOLD};
    case (state_r)
      S_IDLE: begin
        if (accept && (in_command == CMD_COMPUTE)) begin
          state_nxt   = S_MAC;
          i_nxt       = '0;
          j_nxt       = '0;
          cnt_nxt     = '0;
          ctl.acc_clr = 1'b1;
        end
      end
      S_MAC: begin
        ctl.acc_en = pv_r;
        pv_nxt     = rdv_r;
        if (cnt_r < dim_m) begin
          cnt_nxt = cnt_r + DIM_W'(1);
          rdv_nxt = 1'b1;
        end else if (!rdv_r && !pv_r) begin
          state_nxt = S_P0;
        end
      end
      S_P0: begin
        ctl.op_sel = OP_ALPHA_HI;
        state_nxt  = S_P1;
      end
      S_P1: begin
        ctl.op_sel  = OP_ALPHA_LO;
        ctl.tot_sel = TOT_LOAD_HI;
        state_nxt   = S_P2;
      end
      S_P2: begin
        ctl.op_sel  = OP_BETA_C;
        ctl.tot_sel = TOT_ADD;
        state_nxt   = S_P3;
      end
      S_P3: begin
        ctl.tot_sel = TOT_ADD8;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        cnt_nxt       = '0;
        ctl.acc_clr   = 1'b1;
        if ({1'b0, j_r} == dim_k - DIM_W'(1)) begin
          j_nxt = '0;
          if ({1'b0, i_r} == dim_n - DIM_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = S_MAC;
          end
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = S_MAC;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rdv_r       <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      rows_n_r    <= DIM_RESET;
      inner_m_r   <= DIM_RESET;
      cols_k_r    <= DIM_RESET;
      alpha_r     <= ALPHA_RESET;
      beta_r      <= BETA_RESET;
    end else begin
      state_r     <= state_nxt;
      rdv_r       <= rdv_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_ROWS_N:     rows_n_r  <= cfg_wdata[DIM_W-1:0];
          REG_INNER_M:    inner_m_r <= cfg_wdata[DIM_W-1:0];
          REG_COLS_K:     cols_k_r  <= cfg_wdata[DIM_W-1:0];
          REG_ALPHA_GAIN: alpha_r   <= cfg_wdata;
          REG_BETA_GAIN:  beta_r    <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    cnt_r <= cnt_nxt;
    if (state_r == S_OUT) begin
      out_row_r   <= i_r;
      out_col_r   <= j_r;
      out_value_r <= res_value;
      out_sat_r   <= res_sat;
      out_last_r  <= is_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_value     = out_value_r;
  assign out_saturated = out_sat_r;
  assign out_last      = out_last_r;

  gab_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (load_addr),
    .wdata (in_element_value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  gab_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (load_addr),
    .wdata (in_element_value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  gab_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_c_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_addr),
    .rdata (c_rdata)
  );

  gab_datapath u_datapath (
    .clk       (clk),
    .ctl       (ctl),
    .a_data    (a_rdata),
    .b_data    (b_rdata),
    .c_data    (c_rdata),
    .alpha     (alpha_r),
    .beta      (beta_r),
    .res_value (res_value),
    .res_sat   (res_sat)
  );

endmodule

`default_nettype wire
